// ===== design/vlms_pkg.sv =====
// ----------------------------------------------------------------------------
// vlms_pkg: shared types and constants for the vector length statistics block
// Widths of the accumulators, step counts of the iterative units and the
// queue entry that passes from the front part to the back part.
// ----------------------------------------------------------------------------
package vlms_pkg;

  // Bound on the number of vectors in one field.
  localparam int MaxElements   = 1048576;
  localparam int CompW         = 16;
  localparam int SqW           = 2 * CompW;
  localparam int LenW          = CompW;
  localparam int CountW        = 21;
  localparam int SumW          = 37;
  localparam int SqSumW        = 52;
  localparam int WideW         = 74;
  localparam int RootW         = WideW / 2;
  localparam int StepW         = 6;
  localparam int QueueDepth    = 4;
  localparam int QueuePtrW     = 2;

  // Number of root digits for one vector length and for the final spread.
  localparam logic [StepW-1:0] LenSteps  = StepW'(SqW / 2);
  localparam logic [StepW-1:0] WideSteps = StepW'(RootW);
  localparam logic [StepW-1:0] CountSteps = StepW'(CountW);
  localparam logic [StepW-1:0] SumSteps  = StepW'(SumW);

  localparam logic [CountW-1:0] CountMax = CountW'(MaxElements);

  // One queue entry: sum of squared components and the last flag.
  typedef struct packed {
    logic           last;
    logic [SqW-1:0] sq;
  } vlms_entry_t;

endpackage

// ===== design/vlms_front.sv =====
// ----------------------------------------------------------------------------
// vlms_front: input stage
// Takes one vector item, forms the component magnitudes and the sum of their
// squares, and writes the result into the queue.
// ----------------------------------------------------------------------------
module vlms_front import vlms_pkg::*; (
  input  logic                    push,
  input  logic signed [CompW-1:0] comp_x,
  input  logic signed [CompW-1:0] comp_y,
  input  logic                    last_element,
  input  logic                    q_full,
  output logic                    q_wr,
  output vlms_entry_t             q_wr_data
);

  logic [CompW-1:0] raw_x;
  logic [CompW-1:0] raw_y;
  logic [CompW-1:0] mag_x;
  logic [CompW-1:0] mag_y;
  logic [SqW-1:0]   sq_x;
  logic [SqW-1:0]   sq_y;

  // Magnitudes; the most negative code maps onto its unsigned value.
  assign raw_x = comp_x;
  assign raw_y = comp_y;
  assign mag_x = raw_x[CompW-1] ? CompW'(~raw_x + 1'b1) : raw_x;
  assign mag_y = raw_y[CompW-1] ? CompW'(~raw_y + 1'b1) : raw_y;

  // Squares fit in SqW bits, and so does their sum.
  assign sq_x = {{CompW{1'b0}}, mag_x} * {{CompW{1'b0}}, mag_x};
  assign sq_y = {{CompW{1'b0}}, mag_y} * {{CompW{1'b0}}, mag_y};

  assign q_wr           = push && !q_full;
  assign q_wr_data.sq   = sq_x + sq_y;
  assign q_wr_data.last = last_element;

endmodule

// ===== design/vlms_queue.sv =====
// ----------------------------------------------------------------------------
// vlms_queue: short queue between the front and back parts
// A small register queue; the head entry is shown while it is not empty.
// ----------------------------------------------------------------------------
module vlms_queue import vlms_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr,
  input  vlms_entry_t wr_data,
  input  logic        rd,
  output vlms_entry_t rd_data,
  output logic        full,
  output logic        empty
);

  vlms_entry_t          mem_r [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_r;
  logic [QueuePtrW-1:0] rd_ptr_r;
  logic [QueuePtrW:0]   fill_r;

  assign full    = (fill_r == (QueuePtrW+1)'(QueueDepth));
  assign empty   = (fill_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (wr && !rd) begin
        fill_r <= fill_r + 1'b1;
      end else if (rd && !wr) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

// ===== design/vlms_isqrt.sv =====
// ----------------------------------------------------------------------------
// vlms_isqrt: iterative integer square root
// Digit by digit, one root bit per cycle, taken from the top of the radicand.
// After k steps the root is the floor square root of the top 2k bits.
// ----------------------------------------------------------------------------
module vlms_isqrt import vlms_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WideW-1:0] radicand,
  input  logic [StepW-1:0] steps,
  output logic             done,
  output logic [RootW-1:0] root
);

  logic [WideW-1:0] rad_r;
  logic [RootW+2:0] rem_r;
  logic [RootW-1:0] root_r;
  logic [StepW-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [RootW+2:0] rem_sh;
  logic [RootW+2:0] trial;
  logic             fits;

  // One trial subtraction per step.
  assign rem_sh = {rem_r[RootW:0], rad_r[WideW-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  assign done = done_r;
  assign root = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= steps;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rad_r  <= rad_r << 2;
        rem_r  <= fits ? (rem_sh - trial) : rem_sh;
        root_r <= {root_r[RootW-2:0], fits};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == StepW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/vlms_back.sv =====
// ----------------------------------------------------------------------------
// vlms_back: accumulation and final statistics
// Takes queue entries one at a time, finds each length with the shared root
// unit and accumulates it. After the last item it forms the mean and the
// standard deviation with shift-add multiplies, the root unit and a divider.
// ----------------------------------------------------------------------------
module vlms_back import vlms_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  vlms_entry_t       q_rd_data,
  output logic              q_rd,
  input  logic              out_take,
  output logic              out_valid,
  output logic [LenW-1:0]   out_mean,
  output logic [LenW-1:0]   out_std,
  output logic [CountW-1:0] out_total,
  output logic              out_ovf
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LEN, ST_ACC, ST_PREP, ST_MUL_A, ST_MUL_B,
    ST_DIFF, ST_ROOT, ST_DIV_MEAN, ST_DIV_SD, ST_EMIT
  } state_t;

  state_t            state_r;
  logic              last_r;
  logic [LenW-1:0]   len_r;
  logic [SumW-1:0]   s1_r;
  logic [SqSumW-1:0] s2_r;
  logic [CountW-1:0] cnt_r;
  logic              ovf_r;
  logic [WideW-1:0]  mcand_r;
  logic [SumW-1:0]   mplier_r;
  logic [WideW-1:0]  prod_r;
  logic [WideW-1:0]  a_r;
  logic [StepW-1:0]  step_r;
  logic [RootW-1:0]  quot_r;
  logic [CountW:0]   drem_r;
  logic [RootW-1:0]  rootd_r;
  logic [LenW-1:0]   mean_r;
  logic              sq_start_r;
  logic [WideW-1:0]  sq_rad_r;
  logic [StepW-1:0]  sq_steps_r;
  logic              out_valid_r;
  logic [LenW-1:0]   out_mean_r;
  logic [LenW-1:0]   out_std_r;
  logic [CountW-1:0] out_total_r;
  logic              out_ovf_r;

  logic              sq_done;
  logic [RootW-1:0]  sq_root;
  logic [WideW-1:0]  prod_sum;
  logic [CountW+1:0] drem_sh;
  logic              div_fits;
  logic [CountW:0]   drem_nxt;
  logic [RootW-1:0]  quot_nxt;
  logic [SqW-1:0]    len_sq;

  vlms_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start_r),
    .radicand (sq_rad_r),
    .steps    (sq_steps_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  // Shift-add multiply step.
  assign prod_sum = mplier_r[0] ? (prod_r + mcand_r) : prod_r;

  // Restoring divide step by the element count.
  assign drem_sh  = {drem_r, quot_r[RootW-1]};
  assign div_fits = (drem_sh >= {2'b00, cnt_r});
  assign drem_nxt = div_fits ? (CountW+1)'(drem_sh - {2'b00, cnt_r})
                             : drem_sh[CountW:0];
  assign quot_nxt = {quot_r[RootW-2:0], div_fits};

  assign len_sq = {{LenW{1'b0}}, len_r} * {{LenW{1'b0}}, len_r};

  assign q_rd      = (state_r == ST_IDLE) && !q_empty;
  assign out_valid = out_valid_r;
  assign out_mean  = out_mean_r;
  assign out_std   = out_std_r;
  assign out_total = out_total_r;
  assign out_ovf   = out_ovf_r;

  // Sequencer with its datapath and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s1_r        <= '0;
      s2_r        <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      sq_start_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sq_start_r <= 1'b0;
      // The emit state handles a take of the waiting result itself.
      if (out_take && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            last_r <= q_rd_data.last;
            if (cnt_r >= CountMax) begin
              ovf_r   <= 1'b1;
              state_r <= q_rd_data.last ? ST_PREP : ST_IDLE;
            end else begin
              sq_start_r <= 1'b1;
              sq_rad_r   <= {q_rd_data.sq, {(WideW-SqW){1'b0}}};
              sq_steps_r <= LenSteps;
              state_r    <= ST_LEN;
            end
          end
        end
        ST_LEN: begin
          if (sq_done) begin
            len_r   <= sq_root[LenW-1:0];
            s1_r    <= s1_r + SumW'(sq_root[LenW-1:0]);
            state_r <= ST_ACC;
          end
        end
        ST_ACC: begin
          s2_r    <= s2_r + SqSumW'(len_sq);
          cnt_r   <= cnt_r + 1'b1;
          state_r <= last_r ? ST_PREP : ST_IDLE;
        end
        ST_PREP: begin
          mcand_r  <= WideW'(s2_r);
          mplier_r <= SumW'(cnt_r);
          prod_r   <= '0;
          step_r   <= CountSteps;
          state_r  <= ST_MUL_A;
        end
        ST_MUL_A: begin
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          step_r   <= step_r - 1'b1;
          prod_r   <= prod_sum;
          if (step_r == StepW'(1)) begin
            a_r      <= prod_sum;
            mcand_r  <= WideW'(s1_r);
            mplier_r <= s1_r;
            prod_r   <= '0;
            step_r   <= SumSteps;
            state_r  <= ST_MUL_B;
          end
        end
        ST_MUL_B: begin
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          step_r   <= step_r - 1'b1;
          prod_r   <= prod_sum;
          if (step_r == StepW'(1)) begin
            state_r <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          sq_start_r <= 1'b1;
          sq_rad_r   <= (a_r >= prod_r) ? (a_r - prod_r) : '0;
          sq_steps_r <= WideSteps;
          state_r    <= ST_ROOT;
        end
        ST_ROOT: begin
          if (sq_done) begin
            rootd_r <= sq_root;
            quot_r  <= RootW'(s1_r);
            drem_r  <= '0;
            step_r  <= WideSteps;
            state_r <= ST_DIV_MEAN;
          end
        end
        ST_DIV_MEAN: begin
          quot_r <= quot_nxt;
          drem_r <= drem_nxt;
          step_r <= step_r - 1'b1;
          if (step_r == StepW'(1)) begin
            mean_r  <= quot_nxt[LenW-1:0];
            quot_r  <= rootd_r;
            drem_r  <= '0;
            step_r  <= WideSteps;
            state_r <= ST_DIV_SD;
          end
        end
        ST_DIV_SD: begin
          quot_r <= quot_nxt;
          drem_r <= drem_nxt;
          step_r <= step_r - 1'b1;
          if (step_r == StepW'(1)) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid_r || out_take) begin
            out_valid_r <= 1'b1;
            out_mean_r  <= mean_r;
            out_std_r   <= quot_r[LenW-1:0];
            out_total_r <= cnt_r;
            out_ovf_r   <= ovf_r;
            s1_r        <= '0;
            s2_r        <= '0;
            cnt_r       <= '0;
            ovf_r       <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/vector_length_mean_and_std_top.sv =====
// Per item: the back part works on one item at a time, its pace set by the 16-step
// root unit that finds each length; the four-entry queue lets the front take items meanwhile.
// The front goes on taking items while the back part is busy, until the queue is full.
// With the back part idle, the result for a field follows its last item through
// the shift-add multiplies, the 37-step root and the two 37-step divides.
// Reset (synchronous, rst_n low) empties the queue and clears all sums.
// ----------------------------------------------------------------------------
// vector_length_mean_and_std_top: mean and spread of vector lengths
// Front part, queue and back part joined; results leave through a one-entry
// output register.
// ----------------------------------------------------------------------------
module vector_length_mean_and_std_top import vlms_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  logic signed [CompW-1:0] in_comp_x,
  input  logic signed [CompW-1:0] in_comp_y,
  input  logic                    in_last_element,
  output logic                    empty,
  input  logic                    pop,
  output logic [LenW-1:0]         out_mean_length,
  output logic [LenW-1:0]         out_std_length,
  output logic [CountW-1:0]       out_element_total,
  output logic                    out_overflow_flag
);

  vlms_entry_t wr_data;
  vlms_entry_t rd_data;
  logic        q_wr;
  logic        q_rd;
  logic        q_full;
  logic        q_empty;
  logic        out_valid;

  assign full  = q_full;
  assign empty = !out_valid;

  vlms_front u_front (
    .push         (push),
    .comp_x       (in_comp_x),
    .comp_y       (in_comp_y),
    .last_element (in_last_element),
    .q_full       (q_full),
    .q_wr         (q_wr),
    .q_wr_data    (wr_data)
  );

  vlms_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_data (wr_data),
    .rd      (q_rd),
    .rd_data (rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  vlms_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rd_data (rd_data),
    .q_rd      (q_rd),
    .out_take  (pop && out_valid),
    .out_valid (out_valid),
    .out_mean  (out_mean_length),
    .out_std   (out_std_length),
    .out_total (out_element_total),
    .out_ovf   (out_overflow_flag)
  );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for vector_length_mean_and_std_top
// Streams fields of 2-D vectors into the block and works out the mean and
// spread of their lengths on the side. Each result is compared field by
// field with the oldest outstanding expectation, under several idling phases.
// ----------------------------------------------------------------------------
module testbench;
  import vlms_pkg::*;

  localparam int WatchdogLimit = 20000;

  typedef struct {
    logic [LenW-1:0]   mean_len;
    logic [LenW-1:0]   std_len;
    logic [CountW-1:0] total;
    logic              ovf;
  } field_stats_t;

  logic                    clk;
  logic                    rst_n;
  logic                    push;
  logic                    full;
  logic signed [CompW-1:0] in_comp_x;
  logic signed [CompW-1:0] in_comp_y;
  logic                    in_last_element;
  logic                    empty;
  logic                    pop;
  logic [LenW-1:0]         out_mean_length;
  logic [LenW-1:0]         out_std_length;
  logic [CountW-1:0]       out_element_total;
  logic                    out_overflow_flag;

  // Running sums of the field in progress, kept alongside the block.
  logic [SumW-1:0]   len_total;
  logic [SqSumW-1:0] sq_len_total;
  logic [CountW-1:0] vec_count;
  logic              count_ovf;

  field_stats_t pending_stats[$];
  int           fail_count;
  int           items_sent;
  int           fields_checked;
  int           idle_cycles;
  int           sender_idle_pct;
  int           receiver_stall_pct;

  vector_length_mean_and_std_top dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_comp_x(in_comp_x), .in_comp_y(in_comp_y), .in_last_element(in_last_element),
    .empty(empty), .pop(pop),
    .out_mean_length(out_mean_length), .out_std_length(out_std_length),
    .out_element_total(out_element_total), .out_overflow_flag(out_overflow_flag)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Floor of the square root of a wide value, one digit at a time.
  function automatic logic [63:0] floor_root(input logic [127:0] d);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] cc;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c  = r | (64'd1 << b);
      cc = {64'd0, c} * {64'd0, c};
      if (cc <= d) r = c;
    end
    return r;
  endfunction

  function automatic logic [16:0] comp_magnitude(input logic [CompW-1:0] v);
    return v[CompW-1] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
  endfunction

  // Accumulates one accepted vector and, on the last one, queues the result.
  task automatic accumulate_vector(input logic [CompW-1:0] x, input logic [CompW-1:0] y,
                                   input logic last);
    logic [16:0]  ax;
    logic [16:0]  ay;
    logic [63:0]  len;
    logic [127:0] a;
    logic [127:0] b;
    logic [127:0] d;
    logic [63:0]  sd;
    field_stats_t st;
    ax = comp_magnitude(x);
    ay = comp_magnitude(y);
    if (vec_count >= CountMax) begin
      count_ovf = 1'b1;
    end else begin
      len = floor_root(128'(ax) * 128'(ax) + 128'(ay) * 128'(ay));
      len_total    = len_total + SumW'(len);
      sq_len_total = sq_len_total + SqSumW'(len * len);
      vec_count    = vec_count + 1'b1;
    end
    if (last) begin
      a  = 128'(sq_len_total) * 128'(vec_count);
      b  = 128'(len_total) * 128'(len_total);
      d  = (b <= a) ? a - b : '0;
      sd = floor_root(d) / 64'(vec_count);
      st.mean_len = LenW'(64'(len_total) / 64'(vec_count));
      st.std_len  = LenW'(sd);
      st.total    = vec_count;
      st.ovf      = count_ovf;
      pending_stats.push_back(st);
      len_total = '0; sq_len_total = '0; vec_count = '0; count_ovf = 1'b0;
    end
  endtask

  // Watches both handshakes at the rising edge: predicts on input, checks on output.
  always @(posedge clk) begin
    field_stats_t exp_st;
    if (rst_n) begin
      idle_cycles = idle_cycles + 1;
      if (push && !full) begin
        idle_cycles = 0;
        accumulate_vector(in_comp_x, in_comp_y, in_last_element);
      end
      if (pop && !empty) begin
        idle_cycles = 0;
        if (pending_stats.size() == 0) begin
          $error("unexpected result: mean %0d std %0d total %0d", out_mean_length,
                 out_std_length, out_element_total);
          fail_count++;
        end else begin
          exp_st = pending_stats.pop_front();
          fields_checked++;
          if (out_mean_length !== exp_st.mean_len) begin
            $error("mean_length: expected %0d, got %0d", exp_st.mean_len, out_mean_length);
            fail_count++;
          end
          if (out_std_length !== exp_st.std_len) begin
            $error("std_length: expected %0d, got %0d", exp_st.std_len, out_std_length);
            fail_count++;
          end
          if (out_element_total !== exp_st.total) begin
            $error("element_total: expected %0d, got %0d", exp_st.total, out_element_total);
            fail_count++;
          end
          if (out_overflow_flag !== exp_st.ovf) begin
            $error("overflow_flag: expected %0d, got %0d", exp_st.ovf, out_overflow_flag);
            fail_count++;
          end
        end
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("Timeout: no item moved for %0d cycles.", WatchdogLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // The receiver stalls at random, as the current phase asks.
  always @(negedge clk) begin
    pop <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Sends one vector, with random idle cycles before it.
  task automatic send_vector(input logic [CompW-1:0] x, input logic [CompW-1:0] y,
                             input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    in_comp_x = x;
    in_comp_y = y;
    in_last_element = last;
    do @(posedge clk); while (full);
    @(negedge clk);
    push = 1'b0;
    items_sent++;
  endtask

  function automatic logic [CompW-1:0] random_comp();
    case ($urandom_range(5))
      0:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      1:       return CompW'($urandom_range(31)) - 16'd16;
      default: return CompW'($urandom);
    endcase
  endfunction

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
  endtask

  task automatic wait_for_drain();
    while (pending_stats.size() != 0) @(negedge clk);
  endtask

  // Extreme components, single-element fields and three mixed fields of two to five elements.
  task automatic test_directed_extremes();
    send_vector(16'h0000, 16'h0000, 1'b1);
    send_vector(16'h7FFF, 16'h7FFF, 1'b1);
    send_vector(16'h8000, 16'h8000, 1'b1);
    send_vector(16'h8000, 16'h0000, 1'b1);
    send_vector(16'h0000, 16'h7FFF, 1'b0);
    send_vector(16'h0000, 16'h0000, 1'b0);
    send_vector(16'h8000, 16'h7FFF, 1'b1);
    send_vector(16'h0100, 16'h0000, 1'b0);
    send_vector(16'h0000, 16'hFF00, 1'b0);
    send_vector(16'hFFFF, 16'h0001, 1'b0);
    send_vector(16'h0300, 16'h0400, 1'b0);
    send_vector(16'h8000, 16'h8000, 1'b1);
    send_vector(16'h0001, 16'h0001, 1'b1);
    send_vector(16'h5555, 16'hAAAA, 1'b0);
    send_vector(16'hAAAA, 16'h5555, 1'b1);
  endtask

  // Random fields, mostly short, now and then a long one.
  task automatic test_random_fields(input int n_items);
    int left;
    int field_len;
    left = n_items;
    while (left > 0) begin
      field_len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(16, 1);
      for (int i = 0; i < field_len; i++)
        send_vector(random_comp(), random_comp(), i == field_len - 1);
      left -= field_len;
    end
  endtask

  // The sender holds off until every outstanding result has come back.
  task automatic test_pause_until_drained();
    test_random_fields(20);
    wait_for_drain();
    test_random_fields(20);
  endtask

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_comp_x = '0;
    in_comp_y = '0;
    in_last_element = 1'b0;
    len_total = '0; sq_len_total = '0; vec_count = '0; count_ovf = 1'b0;
    fail_count = 0; items_sent = 0; fields_checked = 0; idle_cycles = 0;
    set_idling(0, 0);
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_directed_extremes();
    set_idling(0, 0);
    test_random_fields(220);
    set_idling(83, 0);
    test_random_fields(200);
    set_idling(0, 83);
    test_random_fields(200);
    set_idling(13, 13);
    test_random_fields(200);
    test_pause_until_drained();

    wait_for_drain();
    repeat (400) @(negedge clk);
    $display("Sent %0d vectors in %0d fields, from extreme components to random ones,",
             items_sent, fields_checked);
    $display("under free running, sender idling, receiver stalling and mixed phases.");
    if (fail_count == 0 && pending_stats.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/vlms_pkg.sv
design/vlms_front.sv
design/vlms_queue.sv
design/vlms_isqrt.sv
design/vlms_back.sv
design/vector_length_mean_and_std_top.sv
tb/sv/testbench.sv
